// ----- rtl/rhpm_pkg.sv -----
// Shared types, constants and modular arithmetic helpers of the rolling hash matcher.
package rhpm_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int PTR_W = $clog2(MAX_PATTERN);
	localparam int LEN_W = $clog2(MAX_PATTERN + 1);

	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_PATTERN = 2'd1;
	localparam logic [1:0] OP_TEXT    = 2'd2;

	localparam logic [31:0] HASH_MOD    = 32'd1000000009;
	localparam logic [31:0] HASH_MOD_X2 = 32'd2000000018;
	localparam logic [31:0] HASH_MOD_X3 = 32'd3000000027;
	// 2^30 mod HASH_MOD, used to fold bits above bit 29 back into range
	localparam logic [26:0] FOLD_C      = 27'd73741815;
	localparam logic [7:0]  CHAR_OFFSET = 8'd96;

	typedef logic [29:0] hash_t;
	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [LEN_W-1:0] len_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  kind;
		logic        first;
		logic        chk;
		logic        win_one;
		ptr_t        rd;
		ptr_t        wr;
		logic [31:0] pos;
	} ctl_t;

	// reduce a value below 4*m into [0,m)
	function automatic hash_t mod_small(input logic [31:0] y);
		logic [31:0] r;
		if (y >= HASH_MOD_X3) begin
			r = y - HASH_MOD_X3;
		end else if (y >= HASH_MOD_X2) begin
			r = y - HASH_MOD_X2;
		end else if (y >= HASH_MOD) begin
			r = y - HASH_MOD;
		end else begin
			r = y;
		end
		return r[29:0];
	endfunction

	function automatic hash_t mul31_mod(input hash_t p);
		logic [34:0] x;
		logic [31:0] y;
		x = {p, 5'b0} - 35'(p);
		y = 32'(x[29:0]) + 32'(x[34:30]) * 32'(FOLD_C);
		return mod_small(y);
	endfunction

	// two folds bring a product below 219*2^30 into range
	function automatic hash_t reduce_prod(input logic [37:0] x);
		logic [33:0] y1;
		logic [31:0] y2;
		y1 = 34'(x[29:0]) + 34'(x[37:30]) * 34'(FOLD_C);
		y2 = 32'(y1[29:0]) + 32'(y1[33:30]) * 32'(FOLD_C);
		return mod_small(y2);
	endfunction

	function automatic hash_t add_mod(input hash_t a, input hash_t b);
		logic [30:0] s;
		s = 31'(a) + 31'(b);
		if (s >= 31'(HASH_MOD)) begin
			s = s - 31'(HASH_MOD);
		end
		return s[29:0];
	endfunction

	function automatic hash_t sub_mod(input hash_t a, input hash_t b);
		logic [30:0] s;
		if (a >= b) begin
			s = 31'(a) - 31'(b);
		end else begin
			s = 31'(a) + 31'(HASH_MOD) - 31'(b);
		end
		return s[29:0];
	endfunction

endpackage

// ----- rtl/rhpm_ctrl.sv -----
// Search control state: lengths, powers, ring pointer and the first pipeline stage.
module rhpm_ctrl import rhpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        accept,
	input  logic [1:0]  opcode,
	input  logic [7:0]  character,
	output ctl_t        ctl_s1,
	output logic [7:0]  mag_s1,
	output logic        neg_s1,
	output hash_t       pow_s1
);

	hash_t       ppow_q, tpow_q;
	len_t        plen_q, fill_q;
	logic [31:0] count_q;
	logic        started_q;
	ptr_t        ptr_q;

	hash_t       ppow_d, tpow_d, pow_d;
	len_t        plen_d, fill_d;
	logic [31:0] count_d;
	logic        started_d;
	ptr_t        ptr_d;
	ctl_t        ctl_d;
	logic [7:0]  mag_d;
	logic        neg_d;

	always_comb begin
		ppow_d    = ppow_q;
		tpow_d    = tpow_q;
		plen_d    = plen_q;
		fill_d    = fill_q;
		count_d   = count_q;
		started_d = started_q;
		ptr_d     = ptr_q;
		pow_d     = tpow_q;
		ctl_d     = '0;
		ctl_d.kind = opcode;
		ctl_d.rd   = ptr_q + ptr_t'(1) - plen_q[PTR_W-1:0];
		ctl_d.wr   = ptr_q;
		ctl_d.pos  = count_q + 32'd1 - 32'(plen_q);
		ctl_d.win_one = (plen_q == len_t'(1));
		// signed character value (byte - 96) as magnitude and sign
		if (character >= CHAR_OFFSET) begin
			mag_d = character - CHAR_OFFSET;
			neg_d = 1'b0;
		end else begin
			mag_d = CHAR_OFFSET - character;
			neg_d = 1'b1;
		end
		unique case (opcode)
			OP_CLEAR: begin
				ppow_d    = hash_t'(1);
				tpow_d    = hash_t'(1);
				plen_d    = '0;
				fill_d    = '0;
				count_d   = '0;
				started_d = 1'b0;
				ptr_d     = '0;
				ctl_d.valid = 1'b1;
			end
			OP_PATTERN: begin
				if (!started_q && plen_q < len_t'(MAX_PATTERN)) begin
					pow_d  = ppow_q;
					ppow_d = mul31_mod(ppow_q);
					plen_d = plen_q + len_t'(1);
					ctl_d.valid = 1'b1;
				end
			end
			OP_TEXT: begin
				started_d = 1'b1;
				tpow_d    = mul31_mod(tpow_q);
				if (fill_q < len_t'(MAX_PATTERN)) begin
					fill_d = fill_q + len_t'(1);
				end
				ptr_d   = ptr_q + ptr_t'(1);
				count_d = count_q + 32'd1;
				ctl_d.valid = 1'b1;
				ctl_d.first = !started_q;
				ctl_d.chk   = (plen_q != '0) && (fill_d >= plen_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppow_q    <= hash_t'(1);
			tpow_q    <= hash_t'(1);
			plen_q    <= '0;
			fill_q    <= '0;
			count_q   <= '0;
			started_q <= 1'b0;
			ptr_q     <= '0;
			ctl_s1    <= '0;
		end else if (en) begin
			if (accept) begin
				ppow_q    <= ppow_d;
				tpow_q    <= tpow_d;
				plen_q    <= plen_d;
				fill_q    <= fill_d;
				count_q   <= count_d;
				started_q <= started_d;
				ptr_q     <= ptr_d;
				ctl_s1    <= ctl_d;
			end else begin
				ctl_s1    <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_d;
			neg_s1 <= neg_d;
			pow_s1 <= pow_d;
		end
	end

endmodule

// ----- rtl/rhpm_term.sv -----
// Character term c * 31^k mod m: product stage and reduction stage.
module rhpm_term import rhpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  ctl_t        ctl_s1,
	input  logic [7:0]  mag_s1,
	input  logic        neg_s1,
	input  hash_t       pow_s1,
	output ctl_t        ctl_s2,
	output ctl_t        ctl_s3,
	output hash_t       term_s3
);

	logic [37:0] prod_s2;
	logic        neg_s2;
	hash_t       red;

	always_comb begin
		red = reduce_prod(prod_s2);
		// negate for characters below the offset
		if (neg_s2 && red != '0) begin
			red = hash_t'(HASH_MOD) - red;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= 38'(mag_s1) * 38'(pow_s1);
			neg_s2  <= neg_s1;
			term_s3 <= red;
		end
	end

endmodule

// ----- rtl/rhpm_hash.sv -----
// Pattern, prefix and target hashes, prefix ring and window compare.
module rhpm_hash import rhpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  ctl_t        ctl_s2,
	input  ctl_t        ctl_s3,
	input  hash_t       term_s3,
	output logic        match_s3
);

	hash_t prefix_ring [MAX_PATTERN];
	hash_t phash_q, prefix_q, target_q;
	hash_t ring_rd_s3;
	hash_t prefix_nx, base, cur, tgt;
	logic  is_text;

	assign is_text   = ctl_s3.valid && (ctl_s3.kind == OP_TEXT);
	assign prefix_nx = add_mod(prefix_q, term_s3);
	assign base      = ctl_s3.win_one ? prefix_q : ring_rd_s3;
	assign cur       = sub_mod(prefix_nx, base);
	assign tgt       = ctl_s3.first ? phash_q : target_q;
	assign match_s3  = is_text && ctl_s3.chk && (cur == tgt);

	// ring: written in the hash stage, read one stage earlier with forwarding
	always_ff @(posedge clk) begin
		if (en) begin
			if (is_text) begin
				prefix_ring[ctl_s3.wr] <= prefix_q;
			end
			if (is_text && ctl_s3.wr == ctl_s2.rd) begin
				ring_rd_s3 <= prefix_q;
			end else begin
				ring_rd_s3 <= prefix_ring[ctl_s2.rd];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phash_q  <= '0;
			prefix_q <= '0;
			target_q <= '0;
		end else if (en && ctl_s3.valid) begin
			unique case (ctl_s3.kind)
				OP_CLEAR: begin
					phash_q  <= '0;
					prefix_q <= '0;
					target_q <= '0;
				end
				OP_PATTERN: begin
					phash_q <= add_mod(phash_q, term_s3);
				end
				OP_TEXT: begin
					prefix_q <= prefix_nx;
					if (ctl_s3.chk) begin
						target_q <= mul31_mod(tgt);
					end else begin
						target_q <= tgt;
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- rtl/rolling_hash_pattern_matcher.sv -----
// Rolling hash pattern matcher top level: handshake, pipeline and result register.
// A match word passes the control, product and reduction registers before it is loaded into the result register.
// Throughput: one input word per cycle while no result word is stalled; the whole pipeline advances together.
// A stalled result word freezes every stage, so item_stall follows match_valid && match_stall.
// Pipeline: control stage, product stage, reduction stage, hash stage, result register.
// Reset clears control state and hashes at once; ring contents are left as they are.
module rolling_hash_pattern_matcher import rhpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  opcode,
	input  logic [7:0]  character,
	output logic        match_valid,
	input  logic        match_stall,
	output logic [31:0] match_position
);

	logic  en;
	logic  accept;
	ctl_t  ctl_s1, ctl_s2, ctl_s3;
	logic [7:0] mag_s1;
	logic  neg_s1;
	hash_t pow_s1;
	hash_t term_s3;
	logic  match_s3;

	// advance whenever the result register is empty or is being taken
	assign en         = !(match_valid && match_stall);
	assign item_stall = !en;
	assign accept     = item_valid && en;

	rhpm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.accept    (accept),
		.opcode    (opcode),
		.character (character),
		.ctl_s1    (ctl_s1),
		.mag_s1    (mag_s1),
		.neg_s1    (neg_s1),
		.pow_s1    (pow_s1)
	);

	rhpm_term u_term (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_s1  (ctl_s1),
		.mag_s1  (mag_s1),
		.neg_s1  (neg_s1),
		.pow_s1  (pow_s1),
		.ctl_s2  (ctl_s2),
		.ctl_s3  (ctl_s3),
		.term_s3 (term_s3)
	);

	rhpm_hash u_hash (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_s2   (ctl_s2),
		.ctl_s3   (ctl_s3),
		.term_s3  (term_s3),
		.match_s3 (match_s3)
	);

	// result register: load the hash stage outcome on every advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_valid <= 1'b0;
		end else if (en) begin
			match_valid <= match_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en && match_s3) begin
			match_position <= ctl_s3.pos;
		end
	end

`ifndef SYNTH
	a_term_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s3.valid |-> (32'(term_s3) < HASH_MOD))
		else $error("character term out of modular range");

	a_match_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(match_valid) |->
			$past(ctl_s3.valid && ctl_s3.kind == OP_TEXT && ctl_s3.chk))
		else $error("match word without a checked text word");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(ctl_s2) && $stable(ctl_s3) && $stable(term_s3)))
		else $error("pipeline moved while result stalled");
`endif

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the rolling hash pattern matcher, with a cycle-free search predictor.
module testbench import rhpm_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// opcode value the block has no meaning for
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam longint unsigned MODULUS = 64'd1000000009;
	localparam int unsigned RADIX = 31;
	localparam int TARGET_WORDS = 1850;
	localparam int HOLD_CYCLES = 300;

	// where the expected outcome of a directed word comes from
	typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_MATCH} exp_src_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  ch;
		exp_src_t    src;
		logic [31:0] pos;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic [1:0]  opcode;
	logic [7:0]  character;
	logic        match_valid;
	logic        match_stall;
	logic [31:0] match_position;

	// predicted search state
	hash_t       pat_hash;
	hash_t       pat_pow;
	hash_t       txt_hash;
	hash_t       txt_pow;
	hash_t       target;
	hash_t       prefix_ring [MAX_PATTERN];
	int unsigned pat_len;
	int unsigned fill;
	int unsigned ring_ptr;
	logic [31:0] txt_count;
	bit          text_on;

	// start positions still owed by the block, oldest first
	logic [31:0] expected_starts [$];
	logic [31:0] want_start;

	int  errors;
	int  words_sent;
	int  seq_no;
	int  hold_requests;
	int  holds_done;
	int  hold_left;
	bit  gaps_on;

	// Directed words. Typed-in outcomes are the ones that are obvious by hand:
	// single-character windows, windows that are not full yet, exact repeats.
	stim_row_t directed_rows [24] = '{
		'{OP_CLEAR,   8'h00, EXP_NONE,  32'd0},
		'{OP_PATTERN, 8'h61, EXP_NONE,  32'd0},	// pattern "a"
		'{OP_TEXT,    8'h61, EXP_MATCH, 32'd0},
		'{OP_TEXT,    8'h62, EXP_NONE,  32'd0},
		'{OP_TEXT,    8'h61, EXP_MATCH, 32'd2},
		'{OP_PATTERN, 8'h61, EXP_NONE,  32'd0},	// pattern is frozen once text began
		'{OP_TEXT,    8'h61, EXP_MATCH, 32'd3},
		'{OP_UNUSED,  8'hFF, EXP_NONE,  32'd0},
		'{OP_CLEAR,   8'hFF, EXP_NONE,  32'd0},
		'{OP_TEXT,    8'h00, EXP_NONE,  32'd0},	// empty pattern never matches
		'{OP_TEXT,    8'hFF, EXP_NONE,  32'd0},
		'{OP_CLEAR,   8'h00, EXP_NONE,  32'd0},
		'{OP_PATTERN, 8'h00, EXP_NONE,  32'd0},	// negative character value wraps
		'{OP_PATTERN, 8'hFF, EXP_NONE,  32'd0},
		'{OP_TEXT,    8'h00, EXP_NONE,  32'd0},
		'{OP_TEXT,    8'hFF, EXP_MATCH, 32'd0},
		'{OP_TEXT,    8'h00, EXP_MODEL, 32'd0},
		'{OP_TEXT,    8'hFF, EXP_MATCH, 32'd2},
		'{OP_CLEAR,   8'h00, EXP_NONE,  32'd0},
		'{OP_PATTERN, 8'h61, EXP_NONE,  32'd0},	// pattern "ab"
		'{OP_PATTERN, 8'h62, EXP_NONE,  32'd0},
		'{OP_TEXT,    8'h63, EXP_NONE,  32'd0},
		'{OP_TEXT,    8'h61, EXP_MODEL, 32'd0},
		'{OP_TEXT,    8'h62, EXP_MATCH, 32'd1}
	};

	rolling_hash_pattern_matcher uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.opcode         (opcode),
		.character      (character),
		.match_valid    (match_valid),
		.match_stall    (match_stall),
		.match_position (match_position)
	);

	function automatic hash_t mul_m(input hash_t a, input hash_t b);
		return hash_t'((64'(a) * 64'(b)) % MODULUS);
	endfunction

	function automatic hash_t add_m(input hash_t a, input hash_t b);
		return hash_t'((64'(a) + 64'(b)) % MODULUS);
	endfunction

	// drop everything but the ring contents
	function automatic void restart_search();
		pat_hash = '0;
		pat_pow = hash_t'(1);
		pat_len = 0;
		txt_hash = '0;
		txt_pow = hash_t'(1);
		target = '0;
		txt_count = '0;
		text_on = 1'b0;
		fill = 0;
		ring_ptr = 0;
	endfunction

	// Advance the predicted search by one accepted word and report the window
	// start, if the hash of the window that ends here equals the shifted pattern hash.
	function automatic void advance_search(input logic [1:0] op, input logic [7:0] ch,
			output bit hit, output logic [31:0] start);
		hash_t       v;
		hash_t       window;
		int unsigned rd;
		hit = 1'b0;
		start = '0;
		v = hash_t'((64'(ch) + MODULUS - 64'(CHAR_OFFSET)) % MODULUS);
		case (op)
		OP_CLEAR: begin
			restart_search();
		end
		OP_PATTERN: begin
			// ignore pattern characters past the limit or after text began
			if (!text_on && pat_len < MAX_PATTERN) begin
				pat_hash = add_m(pat_hash, mul_m(v, pat_pow));
				pat_pow = mul_m(pat_pow, hash_t'(RADIX));
				pat_len++;
			end
		end
		OP_TEXT: begin
			if (!text_on) begin
				text_on = 1'b1;
				target = pat_hash;
			end
			prefix_ring[ring_ptr] = txt_hash;
			txt_hash = add_m(txt_hash, mul_m(v, txt_pow));
			txt_pow = mul_m(txt_pow, hash_t'(RADIX));
			if (fill < MAX_PATTERN) begin
				fill++;
			end
			if (pat_len > 0 && fill >= pat_len) begin
				rd = (ring_ptr + MAX_PATTERN + 1 - pat_len) % MAX_PATTERN;
				window = hash_t'((64'(txt_hash) + MODULUS - 64'(prefix_ring[rd])) % MODULUS);
				if (window == target) begin
					hit = 1'b1;
					start = txt_count + 32'd1 - 32'(pat_len);
				end
				target = mul_m(target, hash_t'(RADIX));
			end
			ring_ptr = (ring_ptr + 1) % MAX_PATTERN;
			txt_count++;
		end
		default: begin
		end
		endcase
	endfunction

	// either any byte, or one of the first few lower-case letters
	function automatic logic [7:0] pick_char(input bit full_bytes, input int alpha);
		return full_bytes ? 8'($urandom_range(255)) : 8'(8'h61 + $urandom_range(alpha - 1));
	endfunction

	// Offer one word from a falling edge, hold it until taken, then predict.
	// Leaves time at the next falling edge.
	task automatic send_word(input logic [1:0] op, input logic [7:0] ch,
			input exp_src_t src, input logic [31:0] typed_pos);
		bit          hit;
		logic [31:0] start;
		while (gaps_on && $urandom_range(99) < 17) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		character <= ch;
		@(posedge clk);
		while (item_stall) begin
			@(posedge clk);
		end
		advance_search(op, ch, hit, start);
		if (src == EXP_MATCH) begin
			expected_starts = {expected_starts, typed_pos};
		end else if (src == EXP_MODEL && hit) begin
			expected_starts = {expected_starts, start};
		end
		if (op != OP_UNUSED) begin
			words_sent++;
		end
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#2ms;
		$display("*** FAILED ***");
		$finish;
	end

	// Result side: stall at random, and hold off for a long stretch on request
	// so that the pipeline backs up into the input.
	initial begin
		match_stall = 1'b0;
		hold_left = 0;
		holds_done = 0;
		forever begin
			@(negedge clk);
			if (hold_requests != holds_done) begin
				holds_done = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				match_stall <= 1'b1;
			end else begin
				match_stall <= gaps_on && ($urandom_range(99) < 17);
			end
		end
	end

	// compare each taken result word with the oldest predicted start
	always @(posedge clk) begin
		if (arst_n && match_valid && !match_stall) begin
			if (expected_starts.size() == 0) begin
				$error("match_position: expected no word, actual %0d", match_position);
				errors++;
			end else begin
				want_start = expected_starts.pop_front();
				if (match_position !== want_start) begin
					$error("match_position: expected %0d, actual %0d", want_start,
						match_position);
					errors++;
				end
			end
		end
	end

	initial begin
		int          mode;
		int          alpha;
		int          pat_n;
		int          text_n;
		int          copy_len;
		int          copy_idx;
		bit          full_bytes;
		logic [7:0]  pat_chars [0:69];
		logic [7:0]  c;

		arst_n = 1'b0;
		item_valid = 1'b0;
		opcode = OP_CLEAR;
		character = 8'h00;
		errors = 0;
		words_sent = 0;
		seq_no = 0;
		hold_requests = 0;
		gaps_on = 1'b1;
		restart_search();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part: walk the table
		foreach (directed_rows[i]) begin
			send_word(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].src,
				directed_rows[i].pos);
		end

		// Random part: mostly clean searches (clear, pattern, text seeded with
		// copies of the pattern), some broken ones and some raw noise.
		while (words_sent < TARGET_WORDS) begin
			seq_no++;
			// long stretch with no idling on either side
			gaps_on = !(seq_no >= 30 && seq_no < 60);
			if (seq_no == 15 || seq_no == 80) begin
				// hold the input until every owed result has come out
				item_valid <= 1'b0;
				@(negedge clk);
				while (expected_starts.size() != 0) begin
					@(negedge clk);
				end
			end
			mode = $urandom_range(99);
			full_bytes = ($urandom_range(3) == 0);
			alpha = $urandom_range(1, 3);
			if (mode < 8) begin
				pat_n = $urandom_range(60, 70);	// below, at and past the pattern limit
			end else if (mode < 13) begin
				pat_n = 0;
			end else begin
				pat_n = $urandom_range(1, 6);
			end
			text_n = $urandom_range(0, (pat_n > 8) ? 140 : 40);
			if (seq_no == 10 || seq_no == 70) begin
				// every text word matches while the result side holds off
				hold_requests++;
				full_bytes = 1'b0;
				alpha = 1;
				pat_n = 1;
				text_n = 60;
				mode = 50;
			end
			if (mode >= 90) begin
				repeat ($urandom_range(1, 12)) begin
					send_word(2'($urandom_range(3)), 8'($urandom_range(255)), EXP_MODEL, '0);
				end
			end else begin
				// broken sequences sometimes carry on without a clear
				if (mode < 80 || $urandom_range(1) == 1) begin
					send_word(OP_CLEAR, 8'($urandom_range(255)), EXP_MODEL, '0);
				end
				for (int i = 0; i < pat_n; i++) begin
					pat_chars[i] = pick_char(full_bytes, alpha);
					send_word(OP_PATTERN, pat_chars[i], EXP_MODEL, '0);
				end
				copy_len = 0;
				copy_idx = 0;
				for (int i = 0; i < text_n; i++) begin
					if (copy_idx < copy_len) begin
						c = pat_chars[copy_idx];
						copy_idx++;
					end else if (pat_n > 0 && $urandom_range(99) < 25) begin
						// plant a copy of the pattern as seen by the block
						copy_len = (pat_n < MAX_PATTERN) ? pat_n : MAX_PATTERN;
						c = pat_chars[0];
						copy_idx = 1;
					end else begin
						c = pick_char(full_bytes, alpha);
					end
					if (mode >= 80 && $urandom_range(9) == 0) begin
						// late pattern word or unused opcode inside the text
						send_word($urandom_range(1) ? OP_PATTERN : OP_UNUSED,
							8'($urandom_range(255)), EXP_MODEL, '0);
					end
					send_word(OP_TEXT, c, EXP_MODEL, '0);
				end
			end
		end

		// drain: wait for the owed results, then keep watching for stray words
		item_valid <= 1'b0;
		while (expected_starts.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
